@@ sv/vap_pkg.sv @@
// Shared types, codes and helper functions for the video RAM access port.
package vap_pkg;

    // Video RAM geometry (word count must stay a power of two)
    localparam int RAM_WORDS = 32768;
    localparam int RAM_AW    = $clog2(RAM_WORDS);
    localparam int WORD_W    = 16;

    // Configuration port geometry
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 2;

    // Bus operation codes
    typedef enum logic [2:0] {
        OP_ADDR_LO  = 3'd0,
        OP_ADDR_HI  = 3'd1,
        OP_WRITE_LO = 3'd2,
        OP_WRITE_HI = 3'd3,
        OP_READ_LO  = 3'd4,
        OP_READ_HI  = 3'd5
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_INC_HIGH = 2'd0,
        CFG_REMAP    = 2'd1,
        CFG_INC_SEL  = 2'd2,
        CFG_BLANK    = 2'd3
    } t_cfg_index;

    // Address remap modes
    localparam logic [1:0] REMAP_NONE = 2'd0;
    localparam logic [1:0] REMAP_8    = 2'd1;
    localparam logic [1:0] REMAP_9    = 2'd2;
    localparam logic [1:0] REMAP_10   = 2'd3;

    // Address step selections
    localparam logic [1:0] STEP_1       = 2'd0;
    localparam logic [1:0] STEP_32      = 2'd1;
    localparam logic [1:0] STEP_128     = 2'd2;
    localparam logic [1:0] STEP_128_ALT = 2'd3;

    // Input word
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       in_visible_lines;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] read_byte;
        logic       write_done;
    } t_out_word;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic clear;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_ram;
        logic clear_last;
        logic out_blocked;
    } t_status;

    // Rotate the low address bits by the selected remap
    function automatic logic [WORD_W-1:0] remap_addr(input logic [WORD_W-1:0] a,
                                                     input logic [1:0] mode);
        logic [WORD_W-1:0] r;
        unique case (mode)
            REMAP_8:  r = {a[15:8],  a[4:0], a[7:5]};
            REMAP_9:  r = {a[15:9],  a[5:0], a[8:6]};
            REMAP_10: r = {a[15:10], a[6:0], a[9:7]};
            default:  r = a;
        endcase
        return r;
    endfunction

    // Address step for the selected increment
    function automatic logic [WORD_W-1:0] step_size(input logic [1:0] sel);
        logic [WORD_W-1:0] s;
        case (sel)
            STEP_1:  s = 16'd1;
            STEP_32: s = 16'd32;
            default: s = 16'd128;
        endcase
        return s;
    endfunction

endpackage

@@ sv/vap_ram.sv @@
// Generic single-port RAM with registered read data.
module vap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vap_ctrl.sv @@
// Controller state machine: clearing pass, word accept and RAM access sequencing.
module vap_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  vap_pkg::t_status i_status,
    output logic             o_in_stall,
    output vap_pkg::t_cmd    o_cmd
);

    vap_pkg::t_state r_state;
    vap_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vap_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            vap_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = vap_pkg::ST_IDLE;
                end
            end
            vap_pkg::ST_IDLE: begin
                o_in_stall = i_status.out_blocked;
                if (i_in_valid && !i_status.out_blocked) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.need_ram) begin
                        n_state = vap_pkg::ST_READ;
                    end
                end
            end
            vap_pkg::ST_READ: begin
                n_state = vap_pkg::ST_UPDATE;
            end
            vap_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = vap_pkg::ST_IDLE;
            end
            default: begin
                n_state = vap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/vap_datapath.sv @@
// Datapath: configuration, word address, prefetch latch, video RAM and result register.
module vap_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vap_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [vap_pkg::CFG_DW-1:0]    i_cfg_data,
    input  vap_pkg::t_in_word             i_in_data,
    input  logic                          i_out_stall,
    input  vap_pkg::t_cmd                 i_cmd,
    output vap_pkg::t_status              o_status,
    output logic                          o_out_valid,
    output vap_pkg::t_out_word            o_out_data
);

    // Configuration registers
    logic       r_inc_high, n_inc_high;
    logic [1:0] r_remap,    n_remap;
    logic [1:0] r_inc_sel,  n_inc_sel;
    logic       r_blank,    n_blank;

    // Address and prefetch latch
    logic [vap_pkg::WORD_W-1:0] r_addr,  n_addr;
    logic [vap_pkg::WORD_W-1:0] r_latch, n_latch;

    // Word under way
    logic [2:0] r_op,   n_op;
    logic [7:0] r_data, n_data;
    logic       r_sel,  n_sel;

    // Result register
    logic               r_out_valid, n_out_valid;
    vap_pkg::t_out_word r_out,       n_out;

    // Clearing pass counter
    logic [vap_pkg::RAM_AW-1:0] r_clr_idx, n_clr_idx;

    // RAM port
    logic                       ram_we;
    logic [vap_pkg::RAM_AW-1:0] ram_addr;
    logic [vap_pkg::WORD_W-1:0] ram_wdata;
    logic [vap_pkg::WORD_W-1:0] ram_rdata;
    logic [vap_pkg::WORD_W-1:0] remapped;
    logic [vap_pkg::WORD_W-1:0] next_step_addr;

    // Decode of the offered word
    logic in_ok;
    logic in_sel;
    logic in_is_addr;
    logic in_is_write;
    logic in_is_read;

    assign in_ok       = r_blank || !i_in_data.in_visible_lines;
    assign in_sel      = (r_inc_high == i_in_data.operation[0]);
    assign in_is_addr  = (i_in_data.operation == vap_pkg::OP_ADDR_LO)
                      || (i_in_data.operation == vap_pkg::OP_ADDR_HI);
    assign in_is_write = (i_in_data.operation == vap_pkg::OP_WRITE_LO)
                      || (i_in_data.operation == vap_pkg::OP_WRITE_HI);
    assign in_is_read  = (i_in_data.operation == vap_pkg::OP_READ_LO)
                      || (i_in_data.operation == vap_pkg::OP_READ_HI);

    assign remapped       = vap_pkg::remap_addr(r_addr, r_remap);
    assign next_step_addr = r_addr + vap_pkg::step_size(r_inc_sel);

    // Report status to the controller
    always_comb begin
        o_status.need_ram    = in_ok && (in_is_addr || in_is_write || (in_is_read && in_sel));
        o_status.clear_last  = (r_clr_idx == vap_pkg::RAM_AW'(vap_pkg::RAM_WORDS - 1));
        o_status.out_blocked = r_out_valid && i_out_stall;
    end

    // Drive the RAM port: clearing pass or merge of the written byte
    always_comb begin
        ram_we    = i_cmd.clear;
        ram_addr  = remapped[vap_pkg::RAM_AW-1:0];
        ram_wdata = '0;
        if (i_cmd.clear) begin
            ram_addr = r_clr_idx;
        end else if (i_cmd.update) begin
            if (r_op == vap_pkg::OP_WRITE_LO) begin
                ram_we    = 1'b1;
                ram_wdata = {ram_rdata[15:8], r_data};
            end else if (r_op == vap_pkg::OP_WRITE_HI) begin
                ram_we    = 1'b1;
                ram_wdata = {r_data, ram_rdata[7:0]};
            end
        end
    end

    // Next values of the datapath registers
    always_comb begin
        n_inc_high  = r_inc_high;
        n_remap     = r_remap;
        n_inc_sel   = r_inc_sel;
        n_blank     = r_blank;
        n_addr      = r_addr;
        n_latch     = r_latch;
        n_op        = r_op;
        n_data      = r_data;
        n_sel       = r_sel;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_clr_idx   = r_clr_idx;

        // Take configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                vap_pkg::CFG_INC_HIGH: n_inc_high = i_cfg_data[0];
                vap_pkg::CFG_REMAP:    n_remap    = i_cfg_data;
                vap_pkg::CFG_INC_SEL:  n_inc_sel  = i_cfg_data;
                vap_pkg::CFG_BLANK:    n_blank    = i_cfg_data[0];
                default: ;
            endcase
        end

        // Advance the clearing pass
        if (i_cmd.clear) begin
            n_clr_idx = r_clr_idx + 1'b1;
        end

        // Accept a word: issue its result, apply what needs no RAM access
        if (i_cmd.accept) begin
            n_op        = i_in_data.operation;
            n_data      = i_in_data.data_byte;
            n_sel       = in_sel;
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.write_done = in_ok && in_is_write;
            unique case (i_in_data.operation) inside
                vap_pkg::OP_ADDR_LO: begin
                    n_addr = {r_addr[15:8], i_in_data.data_byte};
                    if (!in_ok) begin
                        n_latch = '0;
                    end
                end
                vap_pkg::OP_ADDR_HI: begin
                    n_addr = {i_in_data.data_byte, r_addr[7:0]};
                    if (!in_ok) begin
                        n_latch = '0;
                    end
                end
                vap_pkg::OP_WRITE_LO, vap_pkg::OP_WRITE_HI: begin
                    if (!in_ok && in_sel) begin
                        n_addr = next_step_addr;
                    end
                end
                vap_pkg::OP_READ_LO, vap_pkg::OP_READ_HI: begin
                    if (i_in_data.operation == vap_pkg::OP_READ_HI) begin
                        n_out.read_byte = r_latch[15:8];
                    end else begin
                        n_out.read_byte = r_latch[7:0];
                    end
                    if (!in_ok && in_sel) begin
                        n_latch = '0;
                        n_addr  = next_step_addr;
                    end
                end
                default: ;
            endcase
        end

        // Finish a RAM access: load the latch after an address set or read, advance after a read or a selected write
        if (i_cmd.update) begin
            unique case (r_op) inside
                vap_pkg::OP_ADDR_LO, vap_pkg::OP_ADDR_HI: begin
                    n_latch = ram_rdata;
                end
                vap_pkg::OP_WRITE_LO, vap_pkg::OP_WRITE_HI: begin
                    if (r_sel) begin
                        n_addr = next_step_addr;
                    end
                end
                vap_pkg::OP_READ_LO, vap_pkg::OP_READ_HI: begin
                    n_latch = ram_rdata;
                    n_addr  = next_step_addr;
                end
                default: ;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_high  <= 1'b0;
            r_remap     <= vap_pkg::REMAP_NONE;
            r_inc_sel   <= vap_pkg::STEP_1;
            r_blank     <= 1'b1;
            r_addr      <= '0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            r_inc_high  <= n_inc_high;
            r_remap     <= n_remap;
            r_inc_sel   <= n_inc_sel;
            r_blank     <= n_blank;
            r_addr      <= n_addr;
            r_latch     <= n_latch;
            r_out_valid <= n_out_valid;
            r_clr_idx   <= n_clr_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_data <= n_data;
        r_sel  <= n_sel;
        r_out  <= n_out;
    end

    // Video RAM
    vap_ram #(
        .WIDTH (vap_pkg::WORD_W),
        .DEPTH (vap_pkg::RAM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/vram_access_port.sv @@
// Top level of the video RAM access port: controller plus datapath.
//
//   channel   direction   handshake                 payload
//   in        to block    i_in_valid / o_in_stall   i_in_data  (t_in_word)
//   out       from block  o_out_valid / i_out_stall o_out_data (t_out_word)
//   cfg       to block    i_cfg_we                  i_cfg_index, i_cfg_data
//
// A word that needs the RAM (address set, data write or refetching read while
// the RAM is accessible) goes through accept, RAM read and update/write-back
// through the single RAM port. Any other word is handled at accept alone.
// The result is loaded into the output register at accept, so a stalled
// result holds the port only while it is still waiting.
// After reset the RAM is cleared one word a cycle, all 32768 words, with
// o_in_stall high; configuration writes are taken during that pass.
module vram_access_port (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vap_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [vap_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  vap_pkg::t_in_word          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output vap_pkg::t_out_word         o_out_data
);

    vap_pkg::t_cmd    cmd;
    vap_pkg::t_status status;

    // Sequence the accesses
    vap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold address, latch, RAM and result
    vap_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/vap_checker.sv @@
// Port-level checker for the video RAM access port, bound to the top level.
module vap_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_stall,
    input  vap_pkg::t_in_word          i_in_data,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  vap_pkg::t_out_word         o_out_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Keep a stalled result payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result payload changed");

    // Present a result right after every accepted word
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word gave no result");

    // A write result never carries a read byte
    a_write_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_done |-> o_out_data.read_byte == 8'd0)
        else $error("write result with nonzero read byte");

    // A completed write needs an accepted write word in the cycle before
    a_done_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_out_data.write_done |->
            ($past(i_in_data.operation) == vap_pkg::OP_WRITE_LO
             || $past(i_in_data.operation) == vap_pkg::OP_WRITE_HI))
        else $error("write_done without a write word");

endmodule

bind vram_access_port vap_checker u_vap_checker (.*);
